// ===== rtl/core/ffba_pkg.sv =====
// Package for the first-fit block allocator.
// Holds widths, codes and the item and table entry types; no dependencies.
package ffba_pkg;

  localparam int NUM_CELLS     = 256;
  localparam int IDX_W         = $clog2(NUM_CELLS);
  localparam int CNT_W         = $clog2(NUM_CELLS + 1);
  localparam int OFF_W         = 23;
  localparam int SIZE_W        = 24;
  localparam int REQ_W         = SIZE_W + 1;
  localparam int ADDR_W        = 32;
  localparam int CFG_W         = 32;
  localparam int CFG_IDX_W     = 1;
  localparam int HEADER_BYTES  = 12;
  localparam int MIN_SPLIT     = HEADER_BYTES + 8;
  localparam int MAX_HEAP      = 8388608;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_LENGTH = 1'd1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_ALLOC_FAILED = 2'd1;
  localparam logic [1:0] ST_UNKNOWN_ADDR = 2'd2;

  typedef struct packed {
    logic              used;
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic              shift;
    logic              load;
  } row_ctl_t;

  typedef struct packed {
    logic              cmd;
    logic [23:0]       alloc_size;
    logic [ADDR_W-1:0] block_address;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] granted_address;
    logic [SIZE_W-1:0] free_bytes;
    logic [SIZE_W-1:0] used_bytes;
    logic [SIZE_W-1:0] peak_free;
    logic [CNT_W-1:0]  block_count;
  } out_t;

endpackage

// ===== rtl/core/ffba_cell.sv =====
// One table cell: holds a single block entry, takes its neighbour's on shift and ld_d on load.
// Depends on ffba_pkg.
module ffba_cell import ffba_pkg::*; (
  input  logic   clk,
  input  logic   shift,
  input  logic   load,
  input  entry_t d,
  input  entry_t ld_d,
  output entry_t q
);

  always_ff @(posedge clk) begin
    if (load) begin
      q <= ld_d;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

// ===== rtl/core/ffba_row.sv =====
// Ring of table cells; the head is read, the tail takes the rewritten entry.
// Depends on ffba_pkg and ffba_cell.
module ffba_row import ffba_pkg::*; (
  input  logic     clk,
  input  row_ctl_t ctl,
  input  entry_t   tail_d,
  input  entry_t   ld_d,
  output entry_t   head,
  output entry_t   nxt,
  output entry_t   nxt2
);

  entry_t q [NUM_CELLS];

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    entry_t d_k;
    logic   ld_k;
    if (k == NUM_CELLS - 1) begin : g_tail
      assign d_k = tail_d;
    end else begin : g_mid
      assign d_k = q[k+1];
    end
    assign ld_k = (k == 0) ? ctl.load : 1'b0;
    ffba_cell u_cell (
      .clk   (clk),
      .shift (ctl.shift),
      .load  (ld_k),
      .d     (d_k),
      .ld_d  (ld_d),
      .q     (q[k])
    );
  end

  assign head = q[0];
  assign nxt  = q[1];
  assign nxt2 = q[2];

endmodule

// ===== rtl/core/first_fit_block_allocator_top.sv =====
// Top level of the first-fit block allocator: sequencer, statistics and item ports.
// Depends on ffba_pkg and ffba_row.
//
// Usage:
//   Configuration: pulse cfg_we with cfg_index (0 heap_base, 1 heap_length) and
//   cfg_data while idle. Each write rebuilds the table into one free block of the
//   clamped length minus the header, or an empty table when too short.
//   Request items arrive on in_valid/in_ready with in_data; one result item per
//   request leaves on out_valid/out_ready with out_data.
//   Each item takes two full turns of the cell ring with a settling step between:
//   the first turn finds the target block, the settling step picks the rewrite, the
//   second turn rewrites the table (split, mark or merge) while summing the
//   statistics. The result item is registered as the done state is left; the
//   next request is taken only once the item is back in idle. The ring advances
//   one cell per cycle, so the ring length sets the time each item takes.
//   in_ready is high only while no item is at work. The result sits in an output
//   register: a new item is taken while it waits, and a finished item holds in
//   the done state until the register is free when the receiver stalls.
//   Reset clears the control state, the heap registers and the block count, so
//   there is no heap until configured; cell contents need no reset.
module first_fit_block_allocator_top import ffba_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_XFORM  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  localparam logic [2:0] M_KEEP  = 3'd0;
  localparam logic [2:0] M_MARK  = 3'd1;
  localparam logic [2:0] M_SPLIT = 3'd2;
  localparam logic [2:0] M_R     = 3'd3;
  localparam logic [2:0] M_L     = 3'd4;
  localparam logic [2:0] M_LR    = 3'd5;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_CELLS - 1);

  logic [2:0]        state;
  logic [IDX_W-1:0]  t;
  in_t               cur;
  logic [REQ_W-1:0]  req;
  logic              found;
  logic [IDX_W-1:0]  tgt;
  logic              tgt_used;
  logic              lfree;
  logic              rfree;
  logic              split;
  logic [ADDR_W-1:0] granted;
  logic [2:0]        mode;
  entry_t            prev;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  newcount;
  logic [SIZE_W-1:0] acc_free;
  logic [SIZE_W-1:0] acc_used;
  logic [SIZE_W-1:0] acc_max;
  logic [1:0]        status;
  logic [CFG_W-1:0]  heap_base;
  logic [CFG_W-1:0]  heap_length;

  row_ctl_t          ctl;
  entry_t            head;
  entry_t            nxt;
  entry_t            nxt2;
  entry_t            tail_d;
  entry_t            ld_d;
  entry_t            v;

  logic [CFG_W-1:0]  new_base;
  logic [CFG_W-1:0]  new_len;
  logic [CFG_W-1:0]  clamp_len;
  logic              rebuild_ok;
  logic [CNT_W-1:0]  ti;
  logic [CNT_W-1:0]  ii;
  logic              live;
  logic [ADDR_W-1:0] head_addr;
  logic              alloc_hit;
  logic              free_hit;
  logic [REQ_W-1:0]  req_in;

  ffba_row u_row (
    .clk    (clk),
    .ctl    (ctl),
    .tail_d (tail_d),
    .ld_d   (ld_d),
    .head   (head),
    .nxt    (nxt),
    .nxt2   (nxt2)
  );

  // Rebuild values: take the register being written with the other as it stands.
  always_comb begin
    new_base = (cfg_index == REG_HEAP_BASE) ? cfg_data : heap_base;
    new_len  = (cfg_index == REG_HEAP_LENGTH) ? cfg_data : heap_length;
    clamp_len = (new_len > CFG_W'(MAX_HEAP)) ? CFG_W'(MAX_HEAP) : new_len;
    rebuild_ok = clamp_len > CFG_W'(HEADER_BYTES);
    ld_d.used = 1'b0;
    ld_d.off  = '0;
    ld_d.size = SIZE_W'(clamp_len - CFG_W'(HEADER_BYTES));
  end

  assign ctl.shift = (state == S_SCAN) || (state == S_XFORM);
  assign ctl.load  = cfg_we && rebuild_ok;

  assign ti = {1'b0, t};
  assign ii = {1'b0, tgt};
  assign live = ti < count;
  assign head_addr = heap_base + {{(ADDR_W-OFF_W){1'b0}}, head.off} + ADDR_W'(HEADER_BYTES);
  assign req_in = (REQ_W'(in_data.alloc_size) + REQ_W'(7)) & ~REQ_W'(7);

  assign alloc_hit = !found && live && (cur.alloc_size != '0) && !head.used &&
                     ({1'b0, head.size} >= req);
  assign free_hit  = !found && live && (cur.block_address != '0) &&
                     (head_addr == cur.block_address);

  // Rewritten entry for the current ring position.
  always_comb begin
    v = head;
    case (mode)
      M_KEEP: v = head;
      M_MARK: begin
        if (ti == ii) v.used = (cur.cmd == CMD_ALLOC);
      end
      M_SPLIT: begin
        if (ti == ii) begin
          v.used = 1'b1;
          v.size = req[SIZE_W-1:0];
        end else if (ti == ii + CNT_W'(1)) begin
          v.used = 1'b0;
          v.off  = prev.off + OFF_W'(HEADER_BYTES) + req[OFF_W-1:0];
          v.size = prev.size - req[SIZE_W-1:0] - SIZE_W'(HEADER_BYTES);
        end else if (ti > ii) begin
          v = prev;
        end
      end
      M_R: begin
        if (ti == ii) begin
          v.used = 1'b0;
          v.size = head.size + SIZE_W'(HEADER_BYTES) + nxt.size;
        end else if (ti > ii) begin
          v = nxt;
        end
      end
      M_L: begin
        if (ti + CNT_W'(1) == ii) begin
          v.used = 1'b0;
          v.size = head.size + SIZE_W'(HEADER_BYTES) + nxt.size;
        end else if (ti + CNT_W'(1) > ii) begin
          v = nxt;
        end
      end
      M_LR: begin
        if (ti + CNT_W'(1) == ii) begin
          v.used = 1'b0;
          v.size = head.size + SIZE_W'(2 * HEADER_BYTES) + nxt.size + nxt2.size;
        end else if (ti + CNT_W'(1) > ii) begin
          v = nxt2;
        end
      end
      default: v = head;
    endcase
  end

  // Scan turn rotates the ring unchanged; rewrite turn feeds the new entry back.
  assign tail_d = (state == S_XFORM) ? v : head;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      heap_base   <= '0;
      heap_length <= '0;
      out_valid   <= 1'b0;
      found       <= 1'b0;
    end else begin
      // Raise the result when the finished item moves out, drop it once taken.
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        heap_base   <= new_base;
        heap_length <= new_len;
        count       <= rebuild_ok ? CNT_W'(1) : '0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur     <= in_data;
            req     <= req_in;
            found   <= 1'b0;
            t       <= '0;
            granted <= '0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          prev <= head;
          if ((cur.cmd == CMD_ALLOC && alloc_hit) || (cur.cmd == CMD_FREE && free_hit)) begin
            found    <= 1'b1;
            tgt      <= t;
            tgt_used <= head.used;
            lfree    <= (t != '0) && !prev.used;
            rfree    <= (ti + CNT_W'(1) < count) && !nxt.used;
            split    <= (count < CNT_W'(NUM_CELLS)) &&
                        ({2'b0, head.size} >= {1'b0, req} + (REQ_W+1)'(MIN_SPLIT));
            if (cur.cmd == CMD_ALLOC) granted <= head_addr;
          end
          t <= t + IDX_W'(1);
          if (t == LAST) state <= S_DECIDE;
        end
        S_DECIDE: begin
          // Settle the rewrite and the result code for the second turn.
          mode     <= M_KEEP;
          newcount <= count;
          acc_free <= '0;
          acc_used <= '0;
          acc_max  <= '0;
          if (cur.cmd == CMD_ALLOC) begin
            status <= found ? ST_OK : ST_ALLOC_FAILED;
            if (found) begin
              mode <= split ? M_SPLIT : M_MARK;
              if (split) newcount <= count + CNT_W'(1);
            end
          end else begin
            status <= (cur.block_address == '0 || found) ? ST_OK : ST_UNKNOWN_ADDR;
            if (found && tgt_used) begin
              if (lfree && rfree) begin
                mode     <= M_LR;
                newcount <= count - CNT_W'(2);
              end else if (rfree) begin
                mode     <= M_R;
                newcount <= count - CNT_W'(1);
              end else if (lfree) begin
                mode     <= M_L;
                newcount <= count - CNT_W'(1);
              end else begin
                mode <= M_MARK;
              end
            end
          end
          state <= S_XFORM;
        end
        S_XFORM: begin
          prev <= head;
          if (ti < newcount) begin
            if (v.used) begin
              acc_used <= acc_used + v.size;
            end else begin
              acc_free <= acc_free + v.size;
              if (v.size > acc_max) acc_max <= v.size;
            end
          end
          t <= t + IDX_W'(1);
          if (t == LAST) begin
            count <= newcount;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // Hold the finished item until the output register is free.
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      out_data.status          <= status;
      out_data.granted_address <= granted;
      out_data.free_bytes      <= acc_free;
      out_data.used_bytes      <= acc_used;
      out_data.peak_free       <= acc_max;
      out_data.block_count     <= count;
    end
  end

endmodule

// ===== rtl/core/ffba_checker.sv =====
// Port-level checks for the first-fit block allocator, bound to the top level.
// Depends on ffba_pkg and first_fit_block_allocator_top.
module ffba_checker import ffba_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_W-1:0]     cfg_data,
  input logic                 in_valid,
  input logic                 in_ready,
  input in_t                  in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input out_t                 out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("next item taken while one is at work");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= ST_UNKNOWN_ADDR)
    else $error("undefined status code");

  a_grant_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.granted_address == '0)
    else $error("address granted on a failed item");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.block_count <= CNT_W'(NUM_CELLS))
    else $error("block count beyond table size");

endmodule

bind first_fit_block_allocator_top ffba_checker u_ffba_checker (.*);
